>>> sv/icsum_pkg.sv
// ----------------------------------------------------------------------------
// icsum_pkg
// Shared types and constants for the streaming Internet checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package icsum_pkg;

    localparam int MAX_BYTES  = 2048;
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int WORD_W     = 16;
    localparam int PROTO_W    = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [1:0] KIND_UDP = 2'd1;
    localparam logic [1:0] KIND_TCP = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_UDP = 5'd17;
    localparam logic [PROTO_W-1:0] PROTO_TCP = 5'd6;
    localparam logic [PROTO_W-1:0] PROTO_NONE = 5'd0;

    localparam logic [CNT_W-1:0] ADDR_BYTES = CNT_W'(8);

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               last;
        logic [PROTO_W-1:0] proto;
        logic [WORD_W-1:0]  len;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/icsum_front.sv
// ----------------------------------------------------------------------------
// icsum_front
// Accepts bytes, pairs them into words, counts the region and builds the
// queue entries, including the closing entry with the pseudo-header terms.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   accept,
    input  wire [7:0]             data_byte,
    input  wire                   last_byte,
    input  wire [1:0]             kind,
    output logic                  push,
    output icsum_pkg::entry_t     entry
);
    import icsum_pkg::*;

    logic [7:0]       held_reg;
    logic [7:0]       held_next;
    logic             odd_reg;
    logic             odd_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       kind_reg;
    logic [1:0]       kind_next;

    logic             first;
    logic             counted;
    logic [1:0]       kind_eff;
    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W-1:0] len_cnt;

    always_comb
    begin
        first    = (count_reg == '0) && !odd_reg;
        kind_eff = first ? kind : kind_reg;
        counted  = count_reg < CNT_W'(MAX_BYTES);
        cnt_new  = counted ? count_reg + CNT_W'(1) : count_reg;
        len_cnt  = (cnt_new >= ADDR_BYTES) ? cnt_new - ADDR_BYTES : '0;

        entry.last = last_byte;
        unique case (kind_eff)
            KIND_UDP: entry.proto = PROTO_UDP;
            KIND_TCP: entry.proto = PROTO_TCP;
            default:  entry.proto = PROTO_NONE;
        endcase
        entry.len = (entry.proto != PROTO_NONE) ? WORD_W'(len_cnt) : '0;

        priority if (counted && odd_reg)
            entry.word = {held_reg, data_byte};
        else if (counted)
            entry.word = {data_byte, 8'h00};
        else if (odd_reg)
            entry.word = {held_reg, 8'h00};
        else
            entry.word = '0;

        push = accept && ((counted && odd_reg) || last_byte);

        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        if (accept)
        begin
            kind_next = kind_eff;
            if (last_byte)
            begin
                held_next  = '0;
                odd_next   = 1'b0;
                count_next = '0;
            end
            else if (counted)
            begin
                if (!odd_reg)
                    held_next = data_byte;
                odd_next   = !odd_reg;
                count_next = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/icsum_fifo.sv
// ----------------------------------------------------------------------------
// icsum_fifo
// Short entry queue between the byte front end and the summing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_fifo (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  icsum_pkg::entry_t     push_entry,
    input  wire                   pop,
    output icsum_pkg::entry_t     head,
    output logic                  full,
    output logic                  empty
);
    import icsum_pkg::*;

    entry_t           slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;

    always_comb
    begin
        full      = fill_reg == (PTR_W + 1)'(FIFO_DEPTH);
        empty     = fill_reg == '0;
        head      = slot_reg[rd_reg];
        wr_next   = push ? wr_reg + PTR_W'(1) : wr_reg;
        rd_next   = pop ? rd_reg + PTR_W'(1) : rd_reg;
        fill_next = fill_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/icsum_back.sv
// ----------------------------------------------------------------------------
// icsum_back
// Accumulates words with end-around carry and, on the closing entry, folds
// in the pseudo-header terms and loads the complemented checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   empty,
    input  icsum_pkg::entry_t     head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [15:0]           m_tdata
);
    import icsum_pkg::*;

    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] csum_reg;
    logic [WORD_W-1:0] csum_next;

    logic [WORD_W+1:0] total;
    logic [WORD_W:0]   fold1;
    logic [WORD_W:0]   fold2;
    logic [WORD_W:0]   acc;
    logic              out_free;

    always_comb
    begin
        out_free = !valid_reg || m_tready;
        pop      = !empty && (!head.last || out_free);

        acc   = {1'b0, sum_reg} + {1'b0, head.word};
        total = (WORD_W + 2)'(sum_reg) + (WORD_W + 2)'(head.word)
              + (WORD_W + 2)'(head.proto) + (WORD_W + 2)'(head.len);
        fold1 = (WORD_W + 1)'(total[WORD_W-1:0]) + (WORD_W + 1)'(total[WORD_W+1:WORD_W]);
        fold2 = (WORD_W + 1)'(fold1[WORD_W-1:0]) + (WORD_W + 1)'(fold1[WORD_W]);

        sum_next   = sum_reg;
        valid_next = valid_reg && !m_tready;
        csum_next  = csum_reg;
        if (pop)
        begin
            if (head.last)
            begin
                sum_next   = '0;
                valid_next = 1'b1;
                csum_next  = ~fold2[WORD_W-1:0];
            end
            else
            begin
                sum_next = acc[WORD_W-1:0] + WORD_W'(acc[WORD_W]);
            end
        end

        m_tvalid = valid_reg;
        m_tdata  = csum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        csum_reg <= csum_next;
    end

endmodule

`default_nettype wire

>>> sv/internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header
// Streaming one's complement Internet checksum with UDP/TCP pseudo-header
// protocol and length terms.
// Result path: the closing entry is written into the queue, then popped by
// the back end, which registers the checksum and its valid; the result is
// delayed further while the queue drains or the output stalls.
// Throughput: one byte per cycle while the queue is not full.
// Reset: rst_n clears the region state, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module internet_checksum_pseudo_header (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tlast,
    input  wire  [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum_value
);
    import icsum_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t push_entry;
    entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    icsum_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .kind      (s_tuser),
        .push      (push),
        .entry     (push_entry)
    );

    icsum_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    icsum_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> sv/icsum_checker.sv
// ----------------------------------------------------------------------------
// icsum_checker
// Port-level checks for the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled without a pending result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_input_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready || !s_tvalid || s_tready)
        else $error("input stalled with output empty");

endmodule

bind internet_checksum_pseudo_header icsum_checker u_icsum_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
